// ===== hdl/bu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// bu2x_pkg: shared types, constants and helpers of the 2x bilinear upscaler
// Configuration layout, the record that travels from the front part to the
// back part, and the channel extract/insert functions.
// ----------------------------------------------------------------------------
package bu2x_pkg;

    // Geometry limits
    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 4096;
    localparam int POS_W         = 13;   // holds any effective width or height
    localparam int COL_W         = 12;   // column index up to the largest MAX_WIDTH
    localparam int ROW_W         = 12;

    // Field widths
    localparam int WORD_W = 32;
    localparam int CH_W   = 5;
    localparam int PIX_W  = 15;
    localparam int QX_W   = 9;
    localparam int QY_W   = 12;

    // Queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd5;

    // Filter modes
    localparam logic [1:0] MODE_PLAIN     = 2'd0;
    localparam logic [1:0] MODE_PLUS      = 2'd1;
    localparam logic [1:0] MODE_ORIG_PLUS = 2'd2;

    // Reset values of the registers
    localparam logic [4:0]  RST_RED_SHIFT    = 5'd10;
    localparam logic [4:0]  RST_GREEN_SHIFT  = 5'd5;
    localparam logic [4:0]  RST_BLUE_SHIFT   = 5'd0;
    localparam logic [9:0]  RST_FRAME_WIDTH  = 10'd240;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd160;

    // Quad kinds, in emission order (bit positions in item_t.kinds)
    localparam int QK_ABOVE      = 0;   // quad of the row above, left of here
    localparam int QK_ABOVE_EDGE = 1;   // quad of the row above, last column
    localparam int QK_ROW        = 2;   // last row, quad left of here
    localparam int QK_CORNER     = 3;   // last row, last column
    localparam int NKINDS        = 4;

    localparam logic [5:0] CH_MASK = 6'h1f;

    typedef struct packed {
        logic [4:0]  red_shift;
        logic [4:0]  green_shift;
        logic [4:0]  blue_shift;
        logic [9:0]  frame_width;
        logic [12:0] frame_height;
        logic [1:0]  filter_mode;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  above_left;
        logic [PIX_W-1:0]  above_right;
        logic [PIX_W-1:0]  prev;
        logic [PIX_W-1:0]  cur;
        logic [NKINDS-1:0] kinds;
    } item_t;

    // Take one 5-bit channel out of a pixel word
    function automatic logic [CH_W-1:0] get_ch(input logic [WORD_W-1:0] word,
                                               input logic [4:0] shift);
        logic [WORD_W-1:0] t;
        t = word >> shift;
        return t[CH_W-1:0] & CH_MASK[CH_W-1:0];
    endfunction

    // Place one 5-bit channel into a pixel word; bits above the top drop out
    function automatic logic [WORD_W-1:0] put_ch(input logic [CH_W-1:0] v,
                                                 input logic [4:0] shift);
        logic [WORD_W-1:0] t;
        t = WORD_W'(v) << shift;
        return t;
    endfunction

endpackage

// ===== hdl/bilinear_2x_upscale_rgb555_fields_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_2x_upscale_rgb555_fields_unit: 2x bilinear upscaler, 5-bit channels
// Top level: configuration registers, front part, record queue, back part.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order, one per cycle; each pixel that completes
// quads yields them in order, one quad per cycle at the output register unless
// out_stall holds it. An ordinary pixel yields one quad, one of the last column
// or of the whole last row two, and the final pixel of a frame four; the quad
// engine at the back sets the pace. An eight-record queue between intake and
// quad engine absorbs the row-end bursts, and intake stalls only when it fills.
// The row store is a single-port-write memory of MAX_WIDTH entries read once per
// pixel; it needs no clearing after reset. Write configuration only while idle.
module bilinear_2x_upscale_rgb555_fields_unit #(
    parameter int MAX_WIDTH = bu2x_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bu2x_pkg::CFG_DATA_W-1:0]   cfg_data,
    // source pixels
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bu2x_pkg::WORD_W-1:0]       source_pixel,
    // quads
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bu2x_pkg::QX_W-1:0]         quad_x,
    output logic [bu2x_pkg::QY_W-1:0]         quad_y,
    output logic [bu2x_pkg::WORD_W-1:0]       upper_left,
    output logic [bu2x_pkg::WORD_W-1:0]       upper_right,
    output logic [bu2x_pkg::WORD_W-1:0]       lower_left,
    output logic [bu2x_pkg::WORD_W-1:0]       lower_right,
    output logic                              last_of_run,
    output logic                              frame_done
);

    bu2x_pkg::cfg_t                  cfg_reg;
    logic                            push_valid, pop, head_valid;
    bu2x_pkg::item_t                 push_item, head_item;
    logic [bu2x_pkg::QCNT_W-1:0]     q_count;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_shift    <= bu2x_pkg::RST_RED_SHIFT;
            cfg_reg.green_shift  <= bu2x_pkg::RST_GREEN_SHIFT;
            cfg_reg.blue_shift   <= bu2x_pkg::RST_BLUE_SHIFT;
            cfg_reg.frame_width  <= bu2x_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= bu2x_pkg::RST_FRAME_HEIGHT;
            cfg_reg.filter_mode  <= bu2x_pkg::MODE_PLAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bu2x_pkg::REG_RED_SHIFT:    cfg_reg.red_shift    <= cfg_data[4:0];
                bu2x_pkg::REG_GREEN_SHIFT:  cfg_reg.green_shift  <= cfg_data[4:0];
                bu2x_pkg::REG_BLUE_SHIFT:   cfg_reg.blue_shift   <= cfg_data[4:0];
                bu2x_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[9:0];
                bu2x_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[12:0];
                bu2x_pkg::REG_FILTER_MODE:  cfg_reg.filter_mode  <= cfg_data[1:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bu2x_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .q_count      (q_count),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    bu2x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    bu2x_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .quad_x      (quad_x),
        .quad_y      (quad_y),
        .upper_left  (upper_left),
        .upper_right (upper_right),
        .lower_left  (lower_left),
        .lower_right (lower_right),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

endmodule

// ===== hdl/bu2x_front.sv =====
// ----------------------------------------------------------------------------
// bu2x_front: pixel intake, position tracking and row store
// Accepts one source pixel per cycle unless stalled, works out its position,
// reads the row above from the row store, queues a classified record.
// ----------------------------------------------------------------------------
module bu2x_front #(
    parameter int MAX_WIDTH = bu2x_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bu2x_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bu2x_pkg::WORD_W-1:0]   source_pixel,
    input  logic [bu2x_pkg::QCNT_W-1:0]   q_count,
    output logic                          push_valid,
    output bu2x_pkg::item_t               push_item
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int PW = bu2x_pkg::POS_W;
    localparam logic [PW-1:0] W_LIMIT = PW'(MAX_WIDTH);
    localparam logic [PW-1:0] H_LIMIT = PW'(bu2x_pkg::MAX_HEIGHT);

    // Position state
    logic [XW-1:0]                  col_reg, col_next;
    logic [bu2x_pkg::ROW_W-1:0]     row_idx_reg, row_idx_next;
    logic [bu2x_pkg::PIX_W-1:0]     prev_pix_reg;

    // Deferred write of the last column
    logic                           pend_v_reg;
    logic [XW-1:0]                  pend_addr_reg;
    logic [bu2x_pkg::PIX_W-1:0]     pend_data_reg;

    // Stage after the row store read
    logic                           s1_v_reg;
    logic [XW-1:0]                  s1_x_reg;
    logic [bu2x_pkg::ROW_W-1:0]     s1_y_reg;
    logic [bu2x_pkg::NKINDS-1:0]    s1_kinds_reg;
    logic [bu2x_pkg::PIX_W-1:0]     s1_cur_reg;
    logic [bu2x_pkg::PIX_W-1:0]     s1_prev_reg;
    logic [bu2x_pkg::PIX_W-1:0]     rd_reg;
    logic [bu2x_pkg::PIX_W-1:0]     ar_hold_reg;

    logic [bu2x_pkg::PIX_W-1:0]     row_mem [MAX_WIDTH];

    logic [PW-1:0]                  w_eff, h_eff, fw, fh, row_inc, y13;
    logic                           wrap_col, last_col, last_row, accept;
    logic [XW-1:0]                  x;
    logic [bu2x_pkg::ROW_W-1:0]     y;
    logic [bu2x_pkg::PIX_W-1:0]     cur;
    logic [bu2x_pkg::NKINDS-1:0]    kinds;
    logic                           own_wr, wr_en, fwd;
    logic [XW-1:0]                  wr_addr;
    logic [bu2x_pkg::PIX_W-1:0]     wr_data;
    logic [bu2x_pkg::QCNT_W:0]      in_flight;

    // Clamp the geometry
    always_comb
    begin
        fw = PW'(cfg.frame_width);
        fh = cfg.frame_height;
        if (fw == '0)
            w_eff = PW'(1);
        else if (fw > W_LIMIT)
            w_eff = W_LIMIT;
        else
            w_eff = fw;
        if (fh == '0)
            h_eff = PW'(1);
        else if (fh > H_LIMIT)
            h_eff = H_LIMIT;
        else
            h_eff = fh;
    end

    // Position of the pixel on the port
    always_comb
    begin
        wrap_col = PW'(col_reg) >= w_eff;
        x        = wrap_col ? '0 : col_reg;
        row_inc  = wrap_col ? PW'(row_idx_reg) + PW'(1) : PW'(row_idx_reg);
        y13      = (row_inc >= h_eff) ? '0 : row_inc;
        y        = y13[bu2x_pkg::ROW_W-1:0];
        last_col = (PW'(x) == w_eff - PW'(1));
        last_row = (y13 == h_eff - PW'(1));
    end

    // Unpack the incoming pixel, red high
    assign cur = {bu2x_pkg::get_ch(source_pixel, cfg.red_shift),
                  bu2x_pkg::get_ch(source_pixel, cfg.green_shift),
                  bu2x_pkg::get_ch(source_pixel, cfg.blue_shift)};

    // Classify which quads this pixel completes
    always_comb
    begin
        kinds = '0;
        kinds[bu2x_pkg::QK_ABOVE]      = (y != '0) && (x != '0);
        kinds[bu2x_pkg::QK_ABOVE_EDGE] = (y != '0) && last_col;
        kinds[bu2x_pkg::QK_ROW]        = last_row && (x != '0);
        kinds[bu2x_pkg::QK_CORNER]     = last_row && last_col;
    end

    // Hold off while the queue could not take every record in flight
    assign in_flight = (bu2x_pkg::QCNT_W+1)'(q_count) + (bu2x_pkg::QCNT_W+1)'(s1_v_reg);
    assign in_stall  = in_flight >= (bu2x_pkg::QCNT_W+1)'(bu2x_pkg::QDEPTH);
    assign accept    = in_valid && !in_stall;

    // Next position
    always_comb
    begin
        if (last_col)
        begin
            col_next     = '0;
            row_idx_next = last_row ? '0 : y + bu2x_pkg::ROW_W'(1);
        end
        else
        begin
            col_next     = x + XW'(1);
            row_idx_next = y;
        end
    end

    // Row store write port: delayed write of the left pixel, or the
    // deferred last-column write in the cycle after the row ends
    assign own_wr  = accept && (x != '0);
    assign wr_en   = pend_v_reg || own_wr;
    assign wr_addr = pend_v_reg ? pend_addr_reg : x - XW'(1);
    assign wr_data = pend_v_reg ? pend_data_reg : prev_pix_reg;
    assign fwd     = pend_v_reg && (pend_addr_reg == x);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[wr_addr] <= wr_data;
        if (accept)
            rd_reg <= fwd ? pend_data_reg : row_mem[x];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_idx_reg  <= '0;
            prev_pix_reg <= '0;
            pend_v_reg   <= 1'b0;
            s1_v_reg     <= 1'b0;
        end
        else
        begin
            s1_v_reg   <= accept;
            pend_v_reg <= accept && last_col;
            if (accept)
            begin
                col_reg      <= col_next;
                row_idx_reg  <= row_idx_next;
                prev_pix_reg <= cur;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg      <= x;
            s1_y_reg      <= y;
            s1_kinds_reg  <= kinds;
            s1_cur_reg    <= cur;
            s1_prev_reg   <= prev_pix_reg;
            pend_addr_reg <= x;
            pend_data_reg <= cur;
        end
        if (s1_v_reg)
            ar_hold_reg <= rd_reg;
    end

    // Build the record; drop pixels that complete no quad
    assign push_valid             = s1_v_reg && (s1_kinds_reg != '0);
    assign push_item.col          = bu2x_pkg::COL_W'(s1_x_reg);
    assign push_item.row          = s1_y_reg;
    assign push_item.above_left   = ar_hold_reg;
    assign push_item.above_right  = rd_reg;
    assign push_item.prev         = s1_prev_reg;
    assign push_item.cur          = s1_cur_reg;
    assign push_item.kinds        = s1_kinds_reg;

    // The deferred write never meets a write of the next pixel
    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> !own_wr)
        else $error("row store write clash");

    // A last-column pixel leaves the next pixel at column zero
    a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col) |=> (col_reg == '0))
        else $error("column did not restart after last column");

endmodule

// ===== hdl/bu2x_queue.sv =====
// ----------------------------------------------------------------------------
// bu2x_queue: record queue between front and back
// Small first-in first-out buffer of classified pixel records.
// ----------------------------------------------------------------------------
module bu2x_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  bu2x_pkg::item_t              push_item,
    input  logic                         pop,
    output logic                         head_valid,
    output bu2x_pkg::item_t              head_item,
    output logic [bu2x_pkg::QCNT_W-1:0]  count
);

    bu2x_pkg::item_t                 entry_reg [bu2x_pkg::QDEPTH];
    logic [bu2x_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [bu2x_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !pop)
            count_next = count_reg + bu2x_pkg::QCNT_W'(1);
        else if (!push_valid && pop)
            count_next = count_reg - bu2x_pkg::QCNT_W'(1);
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push_valid)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + bu2x_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bu2x_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (count_reg != bu2x_pkg::QCNT_W'(bu2x_pkg::QDEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underflow");

endmodule

// ===== hdl/bu2x_back.sv =====
// ----------------------------------------------------------------------------
// bu2x_back: quad generation
// Expands each record into quads, one quad per cycle unless stalled, filters
// the four pixels per channel and repacks them into the output register.
// ----------------------------------------------------------------------------
module bu2x_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bu2x_pkg::cfg_t                cfg,
    input  logic                          head_valid,
    input  bu2x_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bu2x_pkg::QX_W-1:0]     quad_x,
    output logic [bu2x_pkg::QY_W-1:0]     quad_y,
    output logic [bu2x_pkg::WORD_W-1:0]   upper_left,
    output logic [bu2x_pkg::WORD_W-1:0]   upper_right,
    output logic [bu2x_pkg::WORD_W-1:0]   lower_left,
    output logic [bu2x_pkg::WORD_W-1:0]   lower_right,
    output logic                          last_of_run,
    output logic                          frame_done
);

    localparam int NK = bu2x_pkg::NKINDS;

    logic [NK-1:0]                   done_reg, done_next;
    logic                            out_valid_reg;
    logic [bu2x_pkg::QX_W-1:0]       quad_x_reg;
    logic [bu2x_pkg::QY_W-1:0]       quad_y_reg;
    logic [bu2x_pkg::WORD_W-1:0]     ul_reg, ur_reg, ll_reg, lr_reg;
    logic                            last_reg, frame_reg;

    logic [NK-1:0]                   rem, pick;
    logic [1:0]                      kind;
    logic                            is_last, load;
    logic [bu2x_pkg::PIX_W-1:0]      pa, pb, pc, pd;
    logic [bu2x_pkg::COL_W-1:0]      qx;
    logic [bu2x_pkg::ROW_W-1:0]      qy;
    logic [bu2x_pkg::WORD_W-1:0]     ul_w, ur_w, ll_w, lr_w;
    logic [4:0]                      sh [3];

    // Pick the next quad still owed by the head record
    always_comb
    begin
        rem  = head_item.kinds & ~done_reg;
        pick = '0;
        kind = 2'(bu2x_pkg::QK_CORNER);
        priority if (rem[bu2x_pkg::QK_ABOVE])
            kind = 2'(bu2x_pkg::QK_ABOVE);
        else if (rem[bu2x_pkg::QK_ABOVE_EDGE])
            kind = 2'(bu2x_pkg::QK_ABOVE_EDGE);
        else if (rem[bu2x_pkg::QK_ROW])
            kind = 2'(bu2x_pkg::QK_ROW);
        else
            kind = 2'(bu2x_pkg::QK_CORNER);
        pick[kind] = 1'b1;
        is_last = ((rem & ~pick) == '0);
    end

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && is_last;
    assign done_next = load ? (is_last ? '0 : (done_reg | pick)) : done_reg;

    // Neighbors and position of the chosen quad
    always_comb
    begin
        unique case (kind)
            2'(bu2x_pkg::QK_ABOVE):
            begin
                qx = head_item.col - bu2x_pkg::COL_W'(1);
                qy = head_item.row - bu2x_pkg::ROW_W'(1);
                pa = head_item.above_left;
                pb = head_item.above_right;
                pc = head_item.prev;
                pd = head_item.cur;
            end
            2'(bu2x_pkg::QK_ABOVE_EDGE):
            begin
                qx = head_item.col;
                qy = head_item.row - bu2x_pkg::ROW_W'(1);
                pa = head_item.above_right;
                pb = head_item.above_right;
                pc = head_item.cur;
                pd = head_item.cur;
            end
            2'(bu2x_pkg::QK_ROW):
            begin
                qx = head_item.col - bu2x_pkg::COL_W'(1);
                qy = head_item.row;
                pa = head_item.prev;
                pb = head_item.cur;
                pc = head_item.prev;
                pd = head_item.cur;
            end
            default:
            begin
                qx = head_item.col;
                qy = head_item.row;
                pa = head_item.cur;
                pb = head_item.cur;
                pc = head_item.cur;
                pd = head_item.cur;
            end
        endcase
    end

    assign sh[0] = cfg.red_shift;
    assign sh[1] = cfg.green_shift;
    assign sh[2] = cfg.blue_shift;

    // Filter each channel and repack
    always_comb
    begin
        logic [7:0]  ca, cb, cc, cd;
        logic [11:0] s_ul;
        logic [8:0]  s_ur, s_ll;
        logic [9:0]  s_lr;
        logic [7:0]  v_ul;
        ul_w = '0;
        ur_w = '0;
        ll_w = '0;
        lr_w = '0;
        for (int k = 0; k < 3; k++)
        begin
            ca = {pa[10-5*k +: 5], 3'b000};
            cb = {pb[10-5*k +: 5], 3'b000};
            cc = {pc[10-5*k +: 5], 3'b000};
            cd = {pd[10-5*k +: 5], 3'b000};
            unique case (cfg.filter_mode)
                bu2x_pkg::MODE_PLUS:
                begin
                    s_ul = 12'(ca) * 12'd10 + {3'b000, cb, 1'b0} + {3'b000, cc, 1'b0};
                    v_ul = s_ul[11:4];
                end
                bu2x_pkg::MODE_ORIG_PLUS:
                begin
                    s_ul = 12'(ca) * 12'd5 + {3'b000, cb, 1'b0} + 12'(cc);
                    v_ul = s_ul[10:3];
                end
                default:
                begin
                    s_ul = 12'(ca);
                    v_ul = ca;
                end
            endcase
            s_ur = 9'(ca) + 9'(cb);
            s_ll = 9'(ca) + 9'(cc);
            s_lr = 10'(ca) + 10'(cb) + 10'(cc) + 10'(cd);
            ul_w = ul_w | bu2x_pkg::put_ch(v_ul[7:3], sh[k]);
            ur_w = ur_w | bu2x_pkg::put_ch(s_ur[8:4], sh[k]);
            ll_w = ll_w | bu2x_pkg::put_ch(s_ll[8:4], sh[k]);
            lr_w = lr_w | bu2x_pkg::put_ch(s_lr[9:5], sh[k]);
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_x_reg <= qx[bu2x_pkg::QX_W-1:0];
            quad_y_reg <= qy;
            ul_reg     <= ul_w;
            ur_reg     <= ur_w;
            ll_reg     <= ll_w;
            lr_reg     <= lr_w;
            last_reg   <= is_last;
            frame_reg  <= (kind == 2'(bu2x_pkg::QK_CORNER));
        end
    end

    // Output valid and progress through the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign quad_x      = quad_x_reg;
    assign quad_y      = quad_y_reg;
    assign upper_left  = ul_reg;
    assign upper_right = ur_reg;
    assign lower_left  = ll_reg;
    assign lower_right = lr_reg;
    assign last_of_run = last_reg;
    assign frame_done  = frame_reg;

    // The frame corner always closes its run
    a_frame_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_reg) |-> last_reg)
        else $error("frame_done without last_of_run");

    // Partial progress only while a record waits at the head
    a_done_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg != '0) |-> head_valid)
        else $error("quad progress without a record");

endmodule

// ===== verif/upscale_quad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upscale_quad_checker: quad predictor and scoreboard for the 2x upscaler
// Watches the configuration, pixel and quad channels. Every accepted source
// pixel is run through an independent model of the upscaler, and the quads it
// yields are queued in order; every accepted quad is compared field by field
// against the oldest queued quad.
// ----------------------------------------------------------------------------
module upscale_quad_checker
    import bu2x_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [WORD_W-1:0]     source_pixel,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [QX_W-1:0]       quad_x,
    input  logic [QY_W-1:0]       quad_y,
    input  logic [WORD_W-1:0]     upper_left,
    input  logic [WORD_W-1:0]     upper_right,
    input  logic [WORD_W-1:0]     lower_left,
    input  logic [WORD_W-1:0]     lower_right,
    input  logic                  last_of_run,
    input  logic                  frame_done,
    output int                    fail_count,
    output int                    pending,
    output int                    quads_checked
);

    typedef struct packed {
        logic [QX_W-1:0]   qx;
        logic [QY_W-1:0]   qy;
        logic [WORD_W-1:0] ul;
        logic [WORD_W-1:0] ur;
        logic [WORD_W-1:0] ll;
        logic [WORD_W-1:0] lr;
        logic              run_end;
        logic              frame_end;
    } quad_t;

    quad_t expected_quads[$];

    // model state: row above, pixel to the left, position of next pixel
    logic [PIX_W-1:0] row_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] left_pixel;
    int               col_pos;
    int               row_pos;

    // model copy of the registers
    logic [4:0]  sh_red;
    logic [4:0]  sh_green;
    logic [4:0]  sh_blue;
    logic [9:0]  width_reg;
    logic [12:0] height_reg;
    logic [1:0]  mode_reg;

    // Pull the three channels out of a word into r:g:b 5:5:5
    function automatic logic [PIX_W-1:0] to_rgb15(input logic [WORD_W-1:0] word);
        return {5'(word >> sh_red), 5'(word >> sh_green), 5'(word >> sh_blue)};
    endfunction

    // Repack 8-bit channel results; bits shifted past bit 31 drop out
    function automatic logic [WORD_W-1:0] to_word(input int r, input int g, input int b);
        return (WORD_W'(r >> 3) << sh_red) | (WORD_W'(g >> 3) << sh_green)
             | (WORD_W'(b >> 3) << sh_blue);
    endfunction

    // Blend one quad from a, right b, lower c and lower-right d
    function automatic quad_t blend_quad(input int qx, input int qy,
                                         input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b,
                                         input logic [PIX_W-1:0] c,
                                         input logic [PIX_W-1:0] d);
        int    ca, cb, cc, cd;
        int    ul[3];
        int    ur[3];
        int    ll[3];
        int    lr[3];
        quad_t q;
        for (int k = 0; k < 3; k++)
        begin
            ca = int'(a[14-5*k -: 5]) << 3;
            cb = int'(b[14-5*k -: 5]) << 3;
            cc = int'(c[14-5*k -: 5]) << 3;
            cd = int'(d[14-5*k -: 5]) << 3;
            case (mode_reg)
                MODE_PLUS:      ul[k] = (10 * ca + 2 * cb + 2 * cc) >> 4;
                MODE_ORIG_PLUS: ul[k] = (5 * ca + 2 * cb + cc) >> 3;
                default:        ul[k] = ca;
            endcase
            ur[k] = (ca + cb) >> 1;
            ll[k] = (ca + cc) >> 1;
            lr[k] = (ca + cb + cc + cd) >> 2;
        end
        q.qx        = QX_W'(qx);
        q.qy        = QY_W'(qy);
        q.ul        = to_word(ul[0], ul[1], ul[2]);
        q.ur        = to_word(ur[0], ur[1], ur[2]);
        q.ll        = to_word(ll[0], ll[1], ll[2]);
        q.lr        = to_word(lr[0], lr[1], lr[2]);
        q.run_end   = 1'b0;
        q.frame_end = 1'b0;
        return q;
    endfunction

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: quad %s mismatch: expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        quad_t            want_q;
        quad_t            batch [4];
        int               n, w, h, x, y;
        logic [PIX_W-1:0] cur;
        logic             last_col, last_row;
        if (!rst_n)
        begin
            expected_quads.delete();
            left_pixel    = '0;
            col_pos       = 0;
            row_pos       = 0;
            sh_red        = RST_RED_SHIFT;
            sh_green      = RST_GREEN_SHIFT;
            sh_blue       = RST_BLUE_SHIFT;
            width_reg     = RST_FRAME_WIDTH;
            height_reg    = RST_FRAME_HEIGHT;
            mode_reg      = MODE_PLAIN;
            fail_count    = 0;
            quads_checked = 0;
            pending      <= 0;
        end
        else
        begin
            // Compare an accepted quad with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_quads.size() == 0)
                begin
                    $display("%0t: quad (%0d,%0d) with no prediction waiting",
                             $time, quad_x, quad_y);
                    fail_count++;
                end
                else
                begin
                    want_q = expected_quads.pop_front();
                    check_field("quad_x", want_q.qx, quad_x);
                    check_field("quad_y", want_q.qy, quad_y);
                    check_field("upper_left", want_q.ul, upper_left);
                    check_field("upper_right", want_q.ur, upper_right);
                    check_field("lower_left", want_q.ll, lower_left);
                    check_field("lower_right", want_q.lr, lower_right);
                    check_field("last_of_run", want_q.run_end, last_of_run);
                    check_field("frame_done", want_q.frame_end, frame_done);
                    quads_checked++;
                end
            end

            // Track register writes; spare indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RED_SHIFT:    sh_red     = cfg_data[4:0];
                    REG_GREEN_SHIFT:  sh_green   = cfg_data[4:0];
                    REG_BLUE_SHIFT:   sh_blue    = cfg_data[4:0];
                    REG_FRAME_WIDTH:  width_reg  = cfg_data[9:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[12:0];
                    REG_FILTER_MODE:  mode_reg   = cfg_data[1:0];
                    default: ;
                endcase
            end

            // Predict the quads of an accepted pixel
            if (in_valid && !in_stall)
            begin
                w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                       : width_reg;
                h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                      : height_reg;
                // geometry may have shrunk under the current position
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    row_pos++;
                end
                if (row_pos >= h)
                    row_pos = 0;
                x        = col_pos;
                y        = row_pos;
                cur      = to_rgb15(source_pixel);
                last_col = (x == w - 1);
                last_row = (y == h - 1);
                n        = 0;

                if (y >= 1 && x >= 1)
                begin
                    batch[n] = blend_quad(x - 1, y - 1, row_above[x - 1], row_above[x],
                                          left_pixel, cur);
                    n++;
                end
                if (y >= 1 && last_col)
                begin
                    batch[n] = blend_quad(x, y - 1, row_above[x], row_above[x], cur, cur);
                    n++;
                end
                if (last_row && x >= 1)
                begin
                    batch[n] = blend_quad(x - 1, y, left_pixel, cur, left_pixel, cur);
                    n++;
                end
                if (last_row && last_col)
                begin
                    batch[n] = blend_quad(x, y, cur, cur, cur, cur);
                    batch[n].frame_end = 1'b1;
                    n++;
                end
                if (n > 0)
                    batch[n - 1].run_end = 1'b1;
                for (int i = 0; i < n; i++)
                    expected_quads.push_back(batch[i]);

                // delayed row write keeps x-1 and x of the row above readable
                if (x >= 1)
                    row_above[x - 1] = left_pixel;
                if (last_col)
                    row_above[x] = cur;
                left_pixel = cur;

                // advance
                if (last_col)
                begin
                    col_pos = 0;
                    row_pos = last_row ? 0 : y + 1;
                end
                else
                    col_pos = x + 1;
            end
            pending <= expected_quads.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the 2x bilinear upscaler
// Drives register settings and source pixel frames with bursty input and a
// stalling quad receiver; the quad checker predicts and compares every quad.
// Directed frames cover edges, modes and odd geometry, then random frames.
// ----------------------------------------------------------------------------
module tb_top;
    import bu2x_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;    // queue depth plus pipeline
    localparam int RANDOM_PIXELS = 60;
    localparam int FRAME_CAP     = 60;

    // configuration indexes that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [WORD_W-1:0]     source_pixel = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [QX_W-1:0]       quad_x;
    logic [QY_W-1:0]       quad_y;
    logic [WORD_W-1:0]     upper_left;
    logic [WORD_W-1:0]     upper_right;
    logic [WORD_W-1:0]     lower_left;
    logic [WORD_W-1:0]     lower_right;
    logic                  last_of_run;
    logic                  frame_done;

    int fail_count;
    int pending;
    int quads_checked;

    // stimulus-side view of the frame position, used to keep reads of the
    // row store within entries already written
    int pos_col = 0;
    int pos_row = 0;
    int store_span = 0;
    int eff_w = 240;
    int eff_h = 160;
    int frame_left = 0;
    int pixels_sent = 0;
    int settings_applied = 0;
    int burst_left = 0;
    int cycle_count = 0;

    int stall_left = 0;
    int stall_style = 0;

    bilinear_2x_upscale_rgb555_fields_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .quad_x       (quad_x),
        .quad_y       (quad_y),
        .upper_left   (upper_left),
        .upper_right  (upper_right),
        .lower_left   (lower_left),
        .lower_right  (lower_right),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    upscale_quad_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_pixel  (source_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quad_x        (quad_x),
        .quad_y        (quad_y),
        .upper_left    (upper_left),
        .upper_right   (upper_right),
        .lower_left    (lower_left),
        .lower_right   (lower_right),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done),
        .fail_count    (fail_count),
        .pending       (pending),
        .quads_checked (quads_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver stall: switch among a few patterns, including no stall at all
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 4);
            stall_left  <= $urandom_range(20, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            3:       out_stall <= (stall_left % 4 == 0);
            default: out_stall <= (stall_left % 16 < 10);
        endcase
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d quads still expected", cycle_count, pending);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int wrapped_row(input int w, input int h);
        int r;
        r = (pos_col >= w) ? pos_row + 1 : pos_row;
        return (r >= h) ? 0 : r;
    endfunction

    function automatic logic [WORD_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Drop valid, let all predicted quads drain, then let the block settle
    task automatic wait_idle();
        if (in_valid)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Program all registers while idle; a width that would read row store
    // entries never written is pulled back, or the frame restarted
    task automatic apply_setup(input logic [4:0] red, input logic [4:0] green,
                               input logic [4:0] blue, input logic [9:0] w_raw,
                               input logic [12:0] h_raw, input logic [1:0] mode);
        int w, h, c, r;
        w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw;
        h = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
        if (wrapped_row(w, h) >= 1 && w > store_span)
        begin
            if (store_span >= 1)
            begin
                w     = store_span;
                w_raw = 10'(store_span);
            end
            else
            begin
                h     = 1;
                h_raw = 13'd1;
            end
        end
        wait_idle();
        write_reg(REG_RED_SHIFT, CFG_DATA_W'(red));
        write_reg(REG_GREEN_SHIFT, CFG_DATA_W'(green));
        write_reg(REG_BLUE_SHIFT, CFG_DATA_W'(blue));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_raw));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
        write_reg(REG_FILTER_MODE, CFG_DATA_W'(mode));
        c          = (pos_col >= w) ? 0 : pos_col;
        r          = wrapped_row(w, h);
        eff_w      = w;
        eff_h      = h;
        frame_left = (h - r) * w - c;
        settings_applied++;
    endtask

    // Offer one pixel; bursts keep valid high, gaps fall between bursts
    task automatic send_pixel(input logic [WORD_W-1:0] word);
        int x;
        @(negedge clk);
        in_valid     <= 1'b1;
        source_pixel <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;

        // follow the position as the block does
        if (pos_col >= eff_w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= eff_h)
            pos_row = 0;
        x = pos_col;
        if (x == eff_w - 1)
        begin
            store_span = (x + 1 > store_span) ? x + 1 : store_span;
            pos_col    = 0;
            pos_row    = (pos_row == eff_h - 1) ? 0 : pos_row + 1;
        end
        else
        begin
            store_span = (x > store_span) ? x : store_span;
            pos_col    = x + 1;
        end

        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 11);
        end
    endtask

    task automatic send_frame_rest(input int cap);
        int n;
        n = (frame_left < cap) ? frame_left : cap;
        repeat (n) send_pixel(random_pixel());
    endtask

    initial
    begin : stimulus
        int           random_pixels;
        int           n;
        logic [9:0]   w_raw;
        logic [12:0]  h_raw;
        logic [4:0]   shifts [3];

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 2x2 frame, plain mode: extreme pixels, four quads on the last one
        apply_setup(5'd10, 5'd5, 5'd0, 10'd2, 13'd2, MODE_PLAIN);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);

        // zero width and height act as 1x1; mode three acts as plain;
        // shifts at the top lose channel bits; spare indexes do nothing
        apply_setup(5'd31, 5'd27, 5'd0, 10'd0, 13'd0, 2'd3);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_pixel('1);
        send_pixel(32'h8000_0000);

        // single column, plus mode, overlapping channels
        apply_setup(5'd3, 5'd3, 5'd4, 10'd1, 13'd3, MODE_PLUS);
        send_pixel(32'h0000_01ff);
        send_pixel(32'h0000_0155);
        send_pixel('1);

        // single row, original plus mode, swapped channel order
        apply_setup(5'd0, 5'd5, 5'd10, 10'd3, 13'd1, MODE_ORIG_PLUS);
        send_pixel(32'h0000_7fff);
        send_pixel('0);
        send_pixel(32'h0000_5555);

        // saturated height, then shrink the geometry mid-frame
        apply_setup(5'd27, 5'd22, 5'd17, 10'd4, 13'h1fff, MODE_ORIG_PLUS);
        repeat (6) send_pixel(random_pixel());
        apply_setup(5'd10, 5'd5, 5'd0, 10'd2, 13'd3, MODE_PLAIN);
        send_frame_rest(FRAME_CAP);

        // random settings and frames, mostly small, some cut short
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            foreach (shifts[i])
                shifts[i] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(28, 31))
                                                        : 5'($urandom_range(0, 27));
            case ($urandom_range(0, 9))
                0:       w_raw = 10'd0;
                1:       w_raw = 10'd1;
                default: w_raw = 10'($urandom_range(2, 10));
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = 13'd0;
                1:       h_raw = 13'd1;
                2:       h_raw = 13'($urandom_range(MAX_HEIGHT + 1, 8191));
                default: h_raw = 13'($urandom_range(2, 5));
            endcase
            apply_setup(shifts[0], shifts[1], shifts[2], w_raw, h_raw,
                        2'($urandom_range(0, 3)));
            n = pixels_sent;
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 2 * eff_w + 2)) send_pixel(random_pixel());
            else
                send_frame_rest(FRAME_CAP);
            random_pixels += pixels_sent - n;
        end

        // start a single row from a width past the limit, cut short
        apply_setup(5'd10, 5'd5, 5'd0, 10'h3ff, 13'd1, MODE_PLUS);
        send_frame_rest(FRAME_CAP);

        wait_idle();
        $display("Covered %0d source pixels over %0d register settings, %0d quads checked",
                 pixels_sent, settings_applied, quads_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
